// File: rtl/core/bta_pkg.sv
// Shared constants, codes and interface types of the boundary-tag heap allocator.
package bta_pkg;

    // Heap store geometry
    localparam int HEAP_WORDS = 4096;
    localparam int HDR_AW     = $clog2(HEAP_WORDS);
    localparam int IDX_W      = HDR_AW + 1;
    localparam int SIZE_W     = HDR_AW;
    localparam int HDR_W      = SIZE_W + 1;

    // Field widths
    localparam int BASE_W     = 32;
    localparam int HWORDS_W   = 13;
    localparam int REQ_W      = 3;
    localparam int BYTES_W    = 15;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int AMOUNT_W   = 15;
    localparam int NEED_W     = BYTES_W - 1;
    localparam int ALU_W      = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Query amounts above this many words saturate
    localparam int                    AMT_SAT_WORDS = 8191;
    localparam logic [AMOUNT_W-1:0]   AMT_MAX       = '1;
    localparam logic [HWORDS_W-1:0]   HWORDS_RESET  = HWORDS_W'(HEAP_WORDS);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FREE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LARGEST = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TOTAL   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INIT    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FAIL    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_WORDS = 1'b1;

    // Shared adder operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [BYTES_W-1:0] alloc_bytes;
        logic [ADDR_W-1:0]  free_address;
    } cmd_t;

    typedef struct packed {
        logic [BASE_W-1:0]   heap_base;
        logic [HWORDS_W-1:0] heap_words;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
        logic [AMOUNT_W-1:0] amount_bytes;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [HDR_AW-1:0] addr;
        logic [HDR_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic             op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } alu_rsp_t;

    // True when a header index falls inside the physical store.
    function automatic logic in_store(input logic [ALU_W-1:0] idx);
        in_store = (idx < ALU_W'(HEAP_WORDS));
    endfunction

endpackage

// File: rtl/core/bta_hdr_ram.sv
// Single-port header store with registered read data.
module bta_hdr_ram (
    input  logic                          clk,
    input  bta_pkg::mem_req_t             req,
    output logic [bta_pkg::HDR_W-1:0]     rdata
);
    import bta_pkg::*;

    logic [HDR_W-1:0] hdr_mem [HEAP_WORDS];
    logic [HDR_W-1:0] rdata_reg;

    // Read-first port: one write or one read per cycle.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            hdr_mem[req.addr] <= req.wdata;
        end
        rdata_reg <= hdr_mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/bta_alu.sv
// Shared 32-bit adder and subtractor used for the sequencer's sums and subtract-based compares.
module bta_alu (
    input  bta_pkg::alu_req_t req,
    output bta_pkg::alu_rsp_t rsp
);
    import bta_pkg::*;

    logic [ALU_W:0]   total;
    logic [ALU_W-1:0] b_op;

    // On a subtract the carry out is set when a >= b (unsigned).
    always_comb
    begin
        b_op  = (req.op == ALU_SUB) ? ~req.b : req.b;
        total = {1'b0, req.a} + {1'b0, b_op} + (ALU_W + 1)'(req.op == ALU_SUB);
        rsp.sum   = total[ALU_W-1:0];
        rsp.carry = total[ALU_W];
    end

endmodule

// File: rtl/core/bta_seq.sv
// Request sequencer: walks and rewrites block headers through the shared adder.
module bta_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  bta_pkg::cmd_t                 cmd,
    input  bta_pkg::cfg_t                 cfg,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bta_pkg::res_t                 res,
    output bta_pkg::mem_req_t             mem_req,
    input  logic [bta_pkg::HDR_W-1:0]     mem_rdata,
    output bta_pkg::alu_req_t             alu_req,
    input  bta_pkg::alu_rsp_t             alu_rsp
);
    import bta_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_INIT_W0  = 5'd2;
    localparam logic [4:0] S_INIT_W1  = 5'd3;
    localparam logic [4:0] S_AL_RD    = 5'd4;
    localparam logic [4:0] S_AL_CHK   = 5'd5;
    localparam logic [4:0] S_CP_RD    = 5'd6;
    localparam logic [4:0] S_CP_EV    = 5'd7;
    localparam logic [4:0] S_CP_RUN   = 5'd8;
    localparam logic [4:0] S_CP_FL    = 5'd9;
    localparam logic [4:0] S_CP_ADV   = 5'd10;
    localparam logic [4:0] S_CP_DONE  = 5'd11;
    localparam logic [4:0] S_CV_DIFF  = 5'd12;
    localparam logic [4:0] S_CV_SPLIT = 5'd13;
    localparam logic [4:0] S_CV_HDR   = 5'd14;
    localparam logic [4:0] S_CV_ADR0  = 5'd15;
    localparam logic [4:0] S_CV_ADR1  = 5'd16;
    localparam logic [4:0] S_FR_SUB0  = 5'd17;
    localparam logic [4:0] S_FR_SUB1  = 5'd18;
    localparam logic [4:0] S_FR_CHK   = 5'd19;
    localparam logic [4:0] S_FR_RD    = 5'd20;
    localparam logic [4:0] S_FR_WR    = 5'd21;
    localparam logic [4:0] S_DONE     = 5'd22;

    // Control state
    logic [4:0]          state_reg,    state_next;
    logic [IDX_W-1:0]    heap_len_reg, heap_len_next;
    logic [IDX_W-1:0]    fp_reg,       fp_next;
    logic                fpv_reg,      fpv_next;
    logic                init_reg,     init_next;

    // Working registers
    logic [REQ_W-1:0]    req_reg,      req_next;
    logic [BYTES_W-1:0]  bytes_reg,    bytes_next;
    logic [ADDR_W-1:0]   addr_reg,     addr_next;
    logic [NEED_W-1:0]   need_reg,     need_next;
    logic [IDX_W-1:0]    p_reg,        p_next;
    logic [IDX_W-1:0]    best_reg,     best_next;
    logic [IDX_W-1:0]    run_reg,      run_next;
    logic [IDX_W-1:0]    acc_reg,      acc_next;
    logic [SIZE_W-1:0]   sz_reg,       sz_next;
    logic [IDX_W-1:0]    blk_reg,      blk_next;
    logic [HDR_W-1:0]    hdr_reg,      hdr_next;
    logic [ALU_W-1:0]    tmp_reg,      tmp_next;
    logic                oob_reg,      oob_next;
    logic                end_reg,      end_next;
    logic                split_reg,    split_next;
    logic [STATUS_W-1:0] status_reg,   status_next;
    logic [ADDR_W-1:0]   baddr_reg,    baddr_next;
    logic [AMOUNT_W-1:0] amount_reg,   amount_next;

    logic [HDR_W-1:0]    hdr_rd;
    logic [SIZE_W-1:0]   rd_size;
    logic                rd_used;
    logic [SIZE_W-1:0]   blk_size;
    logic [IDX_W-1:0]    init_len;
    logic                is_query;

    // Header read with anything past the heap end seen as an end marker.
    assign hdr_rd   = oob_reg ? '0 : mem_rdata;
    assign rd_size  = hdr_rd[HDR_W-1:1];
    assign rd_used  = hdr_rd[0];
    assign blk_size = hdr_reg[HDR_W-1:1];
    assign is_query = (req_reg == REQ_LARGEST) || (req_reg == REQ_TOTAL);

    // Heap length taken by init, clamped to at least two words and at most the store.
    always_comb
    begin
        priority if (cfg.heap_words < HWORDS_W'(2))
        begin
            init_len = IDX_W'(2);
        end
        else if (ALU_W'(cfg.heap_words) > ALU_W'(HEAP_WORDS))
        begin
            init_len = IDX_W'(HEAP_WORDS);
        end
        else
        begin
            init_len = IDX_W'(cfg.heap_words);
        end
    end

    // Sequencer next state, memory and adder control.
    always_comb
    begin
        state_next    = state_reg;
        heap_len_next = heap_len_reg;
        fp_next       = fp_reg;
        fpv_next      = fpv_reg;
        init_next     = init_reg;
        req_next      = req_reg;
        bytes_next    = bytes_reg;
        addr_next     = addr_reg;
        need_next     = need_reg;
        p_next        = p_reg;
        best_next     = best_reg;
        run_next      = run_reg;
        acc_next      = acc_reg;
        sz_next       = sz_reg;
        blk_next      = blk_reg;
        hdr_next      = hdr_reg;
        tmp_next      = tmp_reg;
        oob_next      = oob_reg;
        end_next      = end_reg;
        split_next    = split_reg;
        status_next   = status_reg;
        baddr_next    = baddr_reg;
        amount_next   = amount_reg;
        mem_req       = '0;
        alu_req       = '0;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    req_next    = cmd.req_type;
                    bytes_next  = cmd.alloc_bytes;
                    addr_next   = cmd.free_address;
                    status_next = STAT_FAIL;
                    baddr_next  = '0;
                    amount_next = '0;
                    state_next  = S_DISP;
                end
            end

            S_DISP:
            begin
                priority if (req_reg == REQ_INIT)
                begin
                    alu_req.op    = ALU_SUB;
                    alu_req.a     = ALU_W'(init_len);
                    alu_req.b     = ALU_W'(1);
                    heap_len_next = init_len;
                    tmp_next      = alu_rsp.sum;
                    state_next    = S_INIT_W0;
                end
                else if (!init_reg || (req_reg > REQ_INIT))
                begin
                    state_next = S_DONE;
                end
                else if (req_reg == REQ_ALLOC)
                begin
                    if (bytes_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Words needed: bytes plus header, rounded up.
                        alu_req.op = ALU_ADD;
                        alu_req.a  = ALU_W'(bytes_reg);
                        alu_req.b  = ALU_W'(7);
                        need_next  = alu_rsp.sum[NEED_W+1:2];
                        state_next = S_AL_RD;
                    end
                end
                else if (req_reg == REQ_FREE)
                begin
                    if (addr_reg == '0)
                    begin
                        status_next = STAT_IGNORED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FR_SUB0;
                    end
                end
                else
                begin
                    p_next     = '0;
                    best_next  = '0;
                    run_next   = '0;
                    acc_next   = '0;
                    end_next   = 1'b0;
                    state_next = S_CP_RD;
                end
            end

            S_INIT_W0:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = '0;
                mem_req.wdata = {tmp_reg[SIZE_W-1:0], 1'b0};
                state_next    = S_INIT_W1;
            end

            S_INIT_W1:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = tmp_reg[HDR_AW-1:0];
                mem_req.wdata = '0;
                fp_next       = '0;
                fpv_next      = 1'b1;
                init_next     = 1'b1;
                status_next   = STAT_OK;
                state_next    = S_DONE;
            end

            S_AL_RD:
            begin
                if (!fpv_reg)
                begin
                    p_next     = '0;
                    best_next  = '0;
                    run_next   = '0;
                    end_next   = 1'b0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    alu_req.op   = ALU_SUB;
                    alu_req.a    = ALU_W'(fp_reg);
                    alu_req.b    = ALU_W'(heap_len_reg);
                    oob_next     = alu_rsp.carry;
                    mem_req.addr = fp_reg[HDR_AW-1:0];
                    state_next   = S_AL_CHK;
                end
            end

            S_AL_CHK:
            begin
                // Fast path when the free-pointer block holds the request.
                hdr_next   = hdr_rd;
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(rd_size);
                alu_req.b  = ALU_W'(need_reg);
                if (alu_rsp.carry)
                begin
                    blk_next   = fp_reg;
                    state_next = S_CV_DIFF;
                end
                else
                begin
                    p_next     = '0;
                    best_next  = '0;
                    run_next   = '0;
                    end_next   = 1'b0;
                    state_next = S_CP_RD;
                end
            end

            S_CP_RD:
            begin
                alu_req.op   = ALU_SUB;
                alu_req.a    = ALU_W'(p_reg);
                alu_req.b    = ALU_W'(heap_len_reg);
                oob_next     = alu_rsp.carry;
                mem_req.addr = p_reg[HDR_AW-1:0];
                state_next   = S_CP_EV;
            end

            S_CP_EV:
            begin
                sz_next = rd_size;
                priority if (rd_size == '0)
                begin
                    end_next   = 1'b1;
                    state_next = (run_reg != '0) ? S_CP_FL : S_CP_DONE;
                end
                else if (rd_used)
                begin
                    state_next = (run_reg != '0) ? S_CP_FL : S_CP_ADV;
                end
                else
                begin
                    alu_req.op = ALU_ADD;
                    alu_req.a  = ALU_W'(p_reg);
                    alu_req.b  = ALU_W'(rd_size);
                    p_next     = alu_rsp.sum[IDX_W-1:0];
                    state_next = S_CP_RUN;
                end
            end

            S_CP_RUN:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(run_reg);
                alu_req.b  = ALU_W'(sz_reg);
                run_next   = alu_rsp.sum[IDX_W-1:0];
                state_next = S_CP_RD;
            end

            S_CP_FL:
            begin
                // Write the merged run back into its first header.
                mem_req.we    = in_store(ALU_W'(best_reg));
                mem_req.addr  = best_reg[HDR_AW-1:0];
                mem_req.wdata = {run_reg[SIZE_W-1:0], 1'b0};
                if (is_query)
                begin
                    if (req_reg == REQ_TOTAL)
                    begin
                        alu_req.op = ALU_ADD;
                        alu_req.a  = ALU_W'(acc_reg);
                        alu_req.b  = ALU_W'(run_reg);
                        acc_next   = alu_rsp.sum[IDX_W-1:0];
                    end
                    else
                    begin
                        alu_req.op = ALU_SUB;
                        alu_req.a  = ALU_W'(acc_reg);
                        alu_req.b  = ALU_W'(run_reg);
                        if (!alu_rsp.carry)
                        begin
                            acc_next = run_reg;
                        end
                    end
                    state_next = end_reg ? S_CP_DONE : S_CP_ADV;
                end
                else
                begin
                    alu_req.op = ALU_SUB;
                    alu_req.a  = ALU_W'(run_reg);
                    alu_req.b  = ALU_W'(need_reg);
                    if (alu_rsp.carry)
                    begin
                        fp_next    = best_reg;
                        fpv_next   = 1'b1;
                        blk_next   = best_reg;
                        hdr_next   = {run_reg[SIZE_W-1:0], 1'b0};
                        state_next = S_CV_DIFF;
                    end
                    else
                    begin
                        state_next = end_reg ? S_CP_DONE : S_CP_ADV;
                    end
                end
            end

            S_CP_ADV:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(p_reg);
                alu_req.b  = ALU_W'(sz_reg);
                p_next     = alu_rsp.sum[IDX_W-1:0];
                best_next  = alu_rsp.sum[IDX_W-1:0];
                run_next   = '0;
                state_next = S_CP_RD;
            end

            S_CP_DONE:
            begin
                if (is_query)
                begin
                    status_next = STAT_OK;
                    if (ALU_W'(acc_reg) > ALU_W'(AMT_SAT_WORDS))
                    begin
                        amount_next = AMT_MAX;
                    end
                    else
                    begin
                        amount_next = AMOUNT_W'({acc_reg, 2'b00});
                    end
                end
                else
                begin
                    fpv_next = 1'b0;
                    fp_next  = '0;
                end
                state_next = S_DONE;
            end

            S_CV_DIFF:
            begin
                // Split only when a spare word is left over.
                alu_req.op = ALU_SUB;
                alu_req.a  = ALU_W'(blk_size);
                alu_req.b  = ALU_W'(need_reg);
                tmp_next   = alu_rsp.sum;
                if (alu_rsp.sum != '0)
                begin
                    split_next = 1'b1;
                    state_next = S_CV_SPLIT;
                end
                else
                begin
                    split_next = 1'b0;
                    fpv_next   = 1'b0;
                    fp_next    = '0;
                    state_next = S_CV_HDR;
                end
            end

            S_CV_SPLIT:
            begin
                alu_req.op    = ALU_ADD;
                alu_req.a     = ALU_W'(blk_reg);
                alu_req.b     = ALU_W'(need_reg);
                fp_next       = alu_rsp.sum[IDX_W-1:0];
                mem_req.we    = in_store(alu_rsp.sum);
                mem_req.addr  = alu_rsp.sum[HDR_AW-1:0];
                mem_req.wdata = {tmp_reg[SIZE_W-1:0], hdr_reg[0]};
                state_next    = S_CV_HDR;
            end

            S_CV_HDR:
            begin
                mem_req.we    = in_store(ALU_W'(blk_reg));
                mem_req.addr  = blk_reg[HDR_AW-1:0];
                mem_req.wdata = {(split_reg ? need_reg[SIZE_W-1:0] : blk_size), 1'b1};
                state_next    = S_CV_ADR0;
            end

            S_CV_ADR0:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = cfg.heap_base;
                alu_req.b  = ALU_W'(blk_reg) << 2;
                tmp_next   = alu_rsp.sum;
                state_next = S_CV_ADR1;
            end

            S_CV_ADR1:
            begin
                alu_req.op  = ALU_ADD;
                alu_req.a   = tmp_reg;
                alu_req.b   = ALU_W'(4);
                baddr_next  = alu_rsp.sum;
                status_next = STAT_OK;
                state_next  = S_DONE;
            end

            S_FR_SUB0:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = addr_reg;
                alu_req.b  = cfg.heap_base;
                tmp_next   = alu_rsp.sum;
                state_next = S_FR_SUB1;
            end

            S_FR_SUB1:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = tmp_reg;
                alu_req.b  = ALU_W'(4);
                tmp_next   = alu_rsp.sum;
                state_next = S_FR_CHK;
            end

            S_FR_CHK:
            begin
                // Reject misaligned pointers and headers past the heap end.
                alu_req.op = ALU_SUB;
                alu_req.a  = tmp_reg >> 2;
                alu_req.b  = ALU_W'(heap_len_reg);
                if ((tmp_reg[1:0] != 2'b00) || alu_rsp.carry)
                begin
                    status_next = STAT_IGNORED;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_FR_RD;
                end
            end

            S_FR_RD:
            begin
                mem_req.addr = tmp_reg[HDR_AW+1:2];
                state_next   = S_FR_WR;
            end

            S_FR_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = tmp_reg[HDR_AW+1:2];
                mem_req.wdata = {mem_rdata[HDR_W-1:1], 1'b0};
                status_next   = STAT_OK;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            heap_len_reg <= '0;
            fp_reg       <= '0;
            fpv_reg      <= 1'b0;
            init_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            heap_len_reg <= heap_len_next;
            fp_reg       <= fp_next;
            fpv_reg      <= fpv_next;
            init_reg     <= init_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        bytes_reg  <= bytes_next;
        addr_reg   <= addr_next;
        need_reg   <= need_next;
        p_reg      <= p_next;
        best_reg   <= best_next;
        run_reg    <= run_next;
        acc_reg    <= acc_next;
        sz_reg     <= sz_next;
        blk_reg    <= blk_next;
        hdr_reg    <= hdr_next;
        tmp_reg    <= tmp_next;
        oob_reg    <= oob_next;
        end_reg    <= end_next;
        split_reg  <= split_next;
        status_reg <= status_next;
        baddr_reg  <= baddr_next;
        amount_reg <= amount_next;
    end

    assign idle              = (state_reg == S_IDLE);
    assign res.status        = status_reg;
    assign res.block_address = baddr_reg;
    assign res.amount_bytes  = amount_reg;

endmodule

// File: rtl/core/boundary_tag_heap_allocator.sv
// Top level of the boundary-tag heap allocator: ports, configuration and result register.
//
//  Channel   Direction  Carries
//  s_*       in         one request beat: kind in tuser, operands in tdata
//  m_*       out        one result beat per request: status in tuser, values in tdata
//  cfg_*     in         register writes: heap_base (index 0), heap_words (index 1)
//
// One request at a time. Init writes the first header and end marker; free checks the
// address and marks its header free; an alloc from the free pointer takes that block,
// splitting it when words are spare. A compaction walk (alloc miss, both queries) reads
// the headers in turn and merges free runs, paced by the single header memory port
// and the one shared adder. Reset clears control state; the header store is not
// cleared and must be set up by an init request. A stalled result waits in the
// output register while the next request is already accepted.
module boundary_tag_heap_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [14:0] alloc_bytes, [46:15] free_address, [47] zero
    input  logic [bta_pkg::S_TDATA_W-1:0]     s_tdata,
    // [2:0] req_type
    input  logic [bta_pkg::REQ_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] block_address, [46:32] amount_bytes, [47] zero
    output logic [bta_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [bta_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                              cfg_we,
    input  logic [bta_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bta_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bta_pkg::*;

    logic [BASE_W-1:0]    heap_base_reg;
    logic [HWORDS_W-1:0]  heap_words_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    cmd_t                 cmd;
    cfg_t                 cfg;
    res_t                 res;
    mem_req_t             mem_req;
    logic [HDR_W-1:0]     mem_rdata;
    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    logic                 seq_idle;
    logic                 res_valid;
    logic                 res_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_words_reg <= HWORDS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HEAP_BASE)
            begin
                heap_base_reg <= cfg_data[BASE_W-1:0];
            end
            else if (cfg_index == CFG_HEAP_WORDS)
            begin
                heap_words_reg <= cfg_data[HWORDS_W-1:0];
            end
        end
    end

    // Unpack the request beat.
    assign cmd.req_type     = s_tuser;
    assign cmd.alloc_bytes  = s_tdata[BYTES_W-1:0];
    assign cmd.free_address = s_tdata[BYTES_W+ADDR_W-1:BYTES_W];
    assign cfg.heap_base    = heap_base_reg;
    assign cfg.heap_words   = heap_words_reg;
    assign s_tready         = seq_idle;

    bta_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid && seq_idle),
        .cmd       (cmd),
        .cfg       (cfg),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    bta_hdr_ram u_hdr_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    bta_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Output register: takes a new result whenever the previous beat is gone.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= M_TDATA_W'({res.amount_bytes, res.block_address});
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
